>>> rtl/core/dmarp_pkg.sv
// ----------------------------------------------------------------------------
// dmarp_pkg: shared types and constants of the DMA descriptor ring producer
// Holds request kinds, status codes, register indexes and the queue item.
// ----------------------------------------------------------------------------
package dmarp_pkg;

  localparam int RingAddrBitsDefault = 28;
  localparam int QueueDepth          = 2;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 22;
  localparam int BurstW   = 22;
  localparam int CountW   = 21;
  localparam int BatchW   = 8;
  localparam int TotalW   = 64;
  localparam int AddrW    = 64;
  localparam int FlagsW   = 2;

  localparam int DescBytes = 32;

  localparam logic [BurstW-1:0] BurstLimit = BurstW'(2097152);
  localparam logic [BatchW-1:0] BatchReset = BatchW'(16);

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgRingEnable    = 2'd0,
    CfgMaxBurst      = 2'd1,
    CfgDoorbellBatch = 2'd2
  } dmarp_cfg_idx_e;

  // Classification made by the front part
  typedef enum logic [1:0] {
    KindOff  = 2'd0,
    KindTick = 2'd1,
    KindZero = 2'd2,
    KindCopy = 2'd3
  } dmarp_kind_e;

  typedef enum logic [1:0] {
    StatusWritten = 2'd0,
    StatusDropped = 2'd1,
    StatusStall   = 2'd2,
    StatusIdle    = 2'd3
  } dmarp_status_e;

  // One classified request as it travels through the queue
  typedef struct packed {
    dmarp_kind_e             kind;
    logic [AddrW-1:0]        src;
    logic [AddrW-1:0]        dst;
    logic [BurstW-1:0]       size;
    logic [FlagsW-1:0]       flags;
  } dmarp_req_t;

endpackage

>>> rtl/core/dmarp_front.sv
// ----------------------------------------------------------------------------
// dmarp_front: request classifier
// Sorts each item into off, idle tick, zero size or copy and clamps the size.
// ----------------------------------------------------------------------------
module dmarp_front (
  input  logic                           command_i,
  input  logic [63:0]                    src_addr_i,
  input  logic [63:0]                    dst_addr_i,
  input  logic [63:0]                    size_bytes_i,
  input  logic [1:0]                     req_flags_i,
  input  logic                           ring_enable_i,
  input  logic [dmarp_pkg::BurstW-1:0]   max_burst_i,
  output dmarp_pkg::dmarp_req_t          req_o
);
  import dmarp_pkg::*;

  logic [BurstW-1:0] limit;
  logic              over;

  // Treat a zero limit as one and cap the limit at the burst ceiling
  always_comb begin
    if (max_burst_i == '0) begin
      limit = BurstW'(1);
    end else if (max_burst_i > BurstLimit) begin
      limit = BurstLimit;
    end else begin
      limit = max_burst_i;
    end
  end

  assign over = (size_bytes_i[63:BurstW] != '0) || (size_bytes_i[BurstW-1:0] > limit);

  always_comb begin
    req_o.src   = src_addr_i;
    req_o.dst   = dst_addr_i;
    req_o.flags = req_flags_i;
    req_o.size  = over ? limit : size_bytes_i[BurstW-1:0];
    if (!ring_enable_i) begin
      req_o.kind = KindOff;
    end else if (command_i) begin
      req_o.kind = KindTick;
    end else if (size_bytes_i == '0) begin
      req_o.kind = KindZero;
    end else begin
      req_o.kind = KindCopy;
    end
  end

endmodule

>>> rtl/core/dmarp_queue.sv
// ----------------------------------------------------------------------------
// dmarp_queue: short register queue between front and back
// Keeps classified items in order so that either side can stall on its own.
// ----------------------------------------------------------------------------
module dmarp_queue #(
  parameter int Width = 8,
  parameter int Depth = dmarp_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);
  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [IdxW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + IdxW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + IdxW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/core/dmarp_back.sv
// ----------------------------------------------------------------------------
// dmarp_back: descriptor writer
// Owns the ring head, doorbell batching and totals; registers each result.
// ----------------------------------------------------------------------------
module dmarp_back #(
  parameter int RING_ADDR_BITS = dmarp_pkg::RingAddrBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  dmarp_pkg::dmarp_req_t          q_req_i,
  input  logic [RING_ADDR_BITS-1:0]      q_rptr_i,
  output logic                           q_pop_o,
  input  logic [dmarp_pkg::BatchW-1:0]   batch_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [RING_ADDR_BITS-1:0]      desc_offset_o,
  output logic [1:0]                     desc_flags_o,
  output logic [63:0]                    desc_src_o,
  output logic [63:0]                    desc_dst_o,
  output logic [20:0]                    desc_count_o,
  output logic                           doorbell_valid_o,
  output logic [RING_ADDR_BITS-1:0]      doorbell_ptr_o,
  output logic [63:0]                    total_descriptors_o,
  output logic [63:0]                    total_bytes_o,
  output logic [63:0]                    total_stalls_o
);
  import dmarp_pkg::*;

  localparam logic [RING_ADDR_BITS-1:0] DescStep = RING_ADDR_BITS'(DescBytes);

  logic [RING_ADDR_BITS-1:0] head_q, head_d;
  logic [BatchW-1:0]         pending_q, pending_d;
  logic [TotalW-1:0]         desc_total_q, desc_total_d;
  logic [TotalW-1:0]         byte_total_q, byte_total_d;
  logic [TotalW-1:0]         stall_total_q, stall_total_d;

  logic                      out_valid_q;
  dmarp_status_e             status_q, status_d;
  logic [RING_ADDR_BITS-1:0] offset_q, offset_d;
  logic [FlagsW-1:0]         flags_q, flags_d;
  logic [AddrW-1:0]          src_q, src_d;
  logic [AddrW-1:0]          dst_q, dst_d;
  logic [CountW-1:0]         count_q, count_d;
  logic                      db_valid_q, db_valid_d;
  logic [RING_ADDR_BITS-1:0] db_ptr_q, db_ptr_d;

  logic                      take;
  logic [RING_ADDR_BITS-1:0] space;
  logic                      no_room;
  logic [BatchW-1:0]         pending_inc;
  logic [BurstW-1:0]         size_m1;

  // Advance when the output register is free or being emptied this cycle
  assign take    = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = take;

  assign space       = q_rptr_i - head_q - RING_ADDR_BITS'(1);
  assign no_room     = (space < DescStep);
  assign pending_inc = pending_q + BatchW'(1);
  assign size_m1     = q_req_i.size - BurstW'(1);

  always_comb begin
    head_d        = head_q;
    pending_d     = pending_q;
    desc_total_d  = desc_total_q;
    byte_total_d  = byte_total_q;
    stall_total_d = stall_total_q;
    status_d      = StatusIdle;
    offset_d      = '0;
    flags_d       = '0;
    src_d         = '0;
    dst_d         = '0;
    count_d       = '0;
    db_valid_d    = 1'b0;
    db_ptr_d      = '0;
    case (q_req_i.kind)
      KindOff: begin
        status_d = StatusIdle;
      end
      KindTick: begin
        if (pending_q != '0) begin
          db_valid_d = 1'b1;
          db_ptr_d   = head_q;
          pending_d  = '0;
        end
      end
      KindZero: begin
        status_d = StatusDropped;
      end
      KindCopy: begin
        if (no_room) begin
          status_d      = StatusStall;
          stall_total_d = stall_total_q + TotalW'(1);
        end else begin
          status_d     = StatusWritten;
          offset_d     = head_q;
          flags_d      = q_req_i.flags;
          src_d        = q_req_i.src;
          dst_d        = q_req_i.dst;
          count_d      = size_m1[CountW-1:0];
          head_d       = head_q + DescStep;
          desc_total_d = desc_total_q + TotalW'(1);
          byte_total_d = byte_total_q + TotalW'(q_req_i.size);
          pending_d    = pending_inc;
          if (pending_inc >= batch_i) begin
            db_valid_d = 1'b1;
            db_ptr_d   = head_q + DescStep;
            pending_d  = '0;
          end
        end
      end
      default: begin
        status_d = StatusIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= '0;
      pending_q     <= '0;
      desc_total_q  <= '0;
      byte_total_q  <= '0;
      stall_total_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (take) begin
        head_q        <= head_d;
        pending_q     <= pending_d;
        desc_total_q  <= desc_total_d;
        byte_total_q  <= byte_total_d;
        stall_total_q <= stall_total_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q   <= status_d;
      offset_q   <= offset_d;
      flags_q    <= flags_d;
      src_q      <= src_d;
      dst_q      <= dst_d;
      count_q    <= count_d;
      db_valid_q <= db_valid_d;
      db_ptr_q   <= db_ptr_d;
    end
  end

  // Totals change only together with a loaded result, so show them directly
  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign desc_offset_o       = offset_q;
  assign desc_flags_o        = flags_q;
  assign desc_src_o          = src_q;
  assign desc_dst_o          = dst_q;
  assign desc_count_o        = count_q;
  assign doorbell_valid_o    = db_valid_q;
  assign doorbell_ptr_o      = db_ptr_q;
  assign total_descriptors_o = desc_total_q;
  assign total_bytes_o       = byte_total_q;
  assign total_stalls_o      = stall_total_q;

  a_head_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (q_req_i.kind == KindCopy) && !no_room |=> head_q == $past(head_q) + DescStep)
    else $error("head did not advance by one descriptor");

  a_stall_keeps_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (q_req_i.kind == KindCopy) && no_room
      |=> $stable(head_q) && (stall_total_q == $past(stall_total_q) + TotalW'(1)))
    else $error("stall moved the head or missed the stall count");

  a_doorbell_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && db_valid_d |=> pending_q == '0)
    else $error("pending count not cleared after doorbell");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(head_q) && $stable(desc_total_q) && $stable(pending_q))
    else $error("ring state changed without a queue pop");

endmodule

>>> rtl/core/dma_descriptor_ring_producer.sv
// ----------------------------------------------------------------------------
// dma_descriptor_ring_producer: DMA descriptor ring producer
// Turns copy requests into linear-copy descriptors with doorbell batching.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item per request or
//   idle tick together with the consumer read pointer. Output channel
//   (out_valid_o / out_ready_i) returns exactly one result item per input
//   item, in order: status, descriptor fields, doorbell and running totals.
//   The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes the
//   ring enable, burst limit and doorbell batch; write only while idle.
//   From acceptance to result valid, the front classifier is combinational
//   and writes the two-entry queue on the accepting edge; the back stage
//   then pops the queue entry, updating the ring head and loading the
//   output register.
//   Throughput is one item per cycle while the receiver takes each result,
//   set by the head update and free-space compare in the back stage.
//   When the receiver stalls the output register holds its result, the back
//   stage stops popping and the queue absorbs up to two more items before
//   in_ready_o drops. Reset clears head, pending count, totals, the queue
//   and the output valid, and returns the registers to their defaults.
// ----------------------------------------------------------------------------
module dma_descriptor_ring_producer #(
  parameter int RING_ADDR_BITS = dmarp_pkg::RingAddrBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dmarp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dmarp_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             command_i,
  input  logic [63:0]                      src_addr_i,
  input  logic [63:0]                      dst_addr_i,
  input  logic [63:0]                      size_bytes_i,
  input  logic [1:0]                       req_flags_i,
  input  logic [RING_ADDR_BITS-1:0]        read_ptr_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic [RING_ADDR_BITS-1:0]        desc_offset_o,
  output logic [1:0]                       desc_flags_o,
  output logic [63:0]                      desc_src_o,
  output logic [63:0]                      desc_dst_o,
  output logic [20:0]                      desc_count_o,
  output logic                             doorbell_valid_o,
  output logic [RING_ADDR_BITS-1:0]        doorbell_ptr_o,
  output logic [63:0]                      total_descriptors_o,
  output logic [63:0]                      total_bytes_o,
  output logic [63:0]                      total_stalls_o
);
  import dmarp_pkg::*;

  localparam int EntryW = $bits(dmarp_req_t) + RING_ADDR_BITS;

  // Configuration registers
  logic              ring_enable_q;
  logic [BurstW-1:0] max_burst_q;
  logic [BatchW-1:0] batch_q;

  // Front to queue
  dmarp_req_t                front_req;
  logic                      push;
  logic                      q_full;

  // Queue to back
  logic                      q_empty;
  logic                      q_pop;
  logic [EntryW-1:0]         q_rdata;
  dmarp_req_t                q_req;
  logic [RING_ADDR_BITS-1:0] q_rptr;

  // Decode register writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_enable_q <= 1'b0;
      max_burst_q   <= BurstLimit;
      batch_q       <= BatchReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRingEnable:    ring_enable_q <= cfg_wdata_i[0];
        CfgMaxBurst:      max_burst_q   <= cfg_wdata_i[BurstW-1:0];
        CfgDoorbellBatch: batch_q       <= cfg_wdata_i[BatchW-1:0];
        default:          ;
      endcase
    end
  end

  // Accept whenever the queue has a free entry
  assign in_ready_o = !q_full;
  assign push       = in_valid_i && !q_full;

  dmarp_front u_front (
    .command_i     (command_i),
    .src_addr_i    (src_addr_i),
    .dst_addr_i    (dst_addr_i),
    .size_bytes_i  (size_bytes_i),
    .req_flags_i   (req_flags_i),
    .ring_enable_i (ring_enable_q),
    .max_burst_i   (max_burst_q),
    .req_o         (front_req)
  );

  dmarp_queue #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({front_req, read_ptr_i}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  assign {q_req, q_rptr} = q_rdata;

  dmarp_back #(
    .RING_ADDR_BITS (RING_ADDR_BITS)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (!q_empty),
    .q_req_i             (q_req),
    .q_rptr_i            (q_rptr),
    .q_pop_o             (q_pop),
    .batch_i             (batch_q),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .desc_offset_o       (desc_offset_o),
    .desc_flags_o        (desc_flags_o),
    .desc_src_o          (desc_src_o),
    .desc_dst_o          (desc_dst_o),
    .desc_count_o        (desc_count_o),
    .doorbell_valid_o    (doorbell_valid_o),
    .doorbell_ptr_o      (doorbell_ptr_o),
    .total_descriptors_o (total_descriptors_o),
    .total_bytes_o       (total_bytes_o),
    .total_stalls_o      (total_stalls_o)
  );

endmodule

>>> test/dma_descriptor_ring_producer_tb.sv
// ----------------------------------------------------------------------------
// dma_descriptor_ring_producer_tb: self-checking bench of the descriptor ring
// Drives copy requests and idle ticks through the valid/ready input channel,
// predicts each result item from a behavioural copy of the ring head, doorbell
// batching and totals, and compares it with the output channel. Both channels
// idle at random. Configuration is rewritten between phases once the block
// has drained.
// ----------------------------------------------------------------------------
module dma_descriptor_ring_producer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmarp_pkg::*;

  localparam int          RingBits   = 28;
  localparam int          CycleLimit = 200000;
  localparam int          PrintLimit = 60;
  localparam bit          CmdCopy    = 1'b0;
  localparam bit          CmdTick    = 1'b1;
  localparam logic [63:0] AllOnes    = 64'hFFFF_FFFF_FFFF_FFFF;

  // One input item as the bench sees it
  typedef struct {
    bit                  cmd;
    logic [63:0]         src;
    logic [63:0]         dst;
    logic [63:0]         size;
    logic [1:0]          flags;
    logic [RingBits-1:0] rptr;
  } copy_req_t;

  // One result item as the block should return it
  typedef struct {
    dmarp_status_e       status;
    logic [RingBits-1:0] offset;
    logic [1:0]          flags;
    logic [63:0]         src;
    logic [63:0]         dst;
    logic [20:0]         count;
    logic                db_valid;
    logic [RingBits-1:0] db_ptr;
    logic [63:0]         n_desc;
    logic [63:0]         n_bytes;
    logic [63:0]         n_stall;
  } ring_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                command_i   = 1'b0;
  logic [63:0]         src_addr_i  = '0;
  logic [63:0]         dst_addr_i  = '0;
  logic [63:0]         size_bytes_i = '0;
  logic [1:0]          req_flags_i = '0;
  logic [RingBits-1:0] read_ptr_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          status_o;
  logic [RingBits-1:0] desc_offset_o;
  logic [1:0]          desc_flags_o;
  logic [63:0]         desc_src_o;
  logic [63:0]         desc_dst_o;
  logic [20:0]         desc_count_o;
  logic                doorbell_valid_o;
  logic [RingBits-1:0] doorbell_ptr_o;
  logic [63:0]         total_descriptors_o;
  logic [63:0]         total_bytes_o;
  logic [63:0]         total_stalls_o;

  // Behavioural copy of the block: ring state and configuration
  logic [RingBits-1:0] ring_head;
  logic [7:0]          batch_fill;
  logic [63:0]         desc_total;
  logic [63:0]         bytes_total;
  logic [63:0]         stall_count;
  logic                ring_on;
  logic [BurstW-1:0]   burst_cap;
  logic [BatchW-1:0]   batch_size;

  ring_result_t        ring_results_q[$];
  int                  error_count = 0;
  int                  cycle_count = 0;
  // Set for a stretch in which neither side idles
  bit                  steady = 1'b0;

  dma_descriptor_ring_producer #(
    .RING_ADDR_BITS(RingBits)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .src_addr_i         (src_addr_i),
    .dst_addr_i         (dst_addr_i),
    .size_bytes_i       (size_bytes_i),
    .req_flags_i        (req_flags_i),
    .read_ptr_i         (read_ptr_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .desc_offset_o      (desc_offset_o),
    .desc_flags_o       (desc_flags_o),
    .desc_src_o         (desc_src_o),
    .desc_dst_o         (desc_dst_o),
    .desc_count_o       (desc_count_o),
    .doorbell_valid_o   (doorbell_valid_o),
    .doorbell_ptr_o     (doorbell_ptr_o),
    .total_descriptors_o(total_descriptors_o),
    .total_bytes_o      (total_bytes_o),
    .total_stalls_o     (total_stalls_o)
  );

  always #4 clk_i = ~clk_i;

  // Hard stop: a hung handshake or a lost result ends here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("dma_descriptor_ring_producer_tb failed");
      $finish;
    end
  end

  // Receiver: drop ready with a chance of about one in five, unless in a steady stretch
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 20);
  end

  // Print one line per mismatch (up to a cap) and count every one
  task automatic report_mismatch(input string msg);
    if (error_count < PrintLimit) $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Work out the result of one accepted item and advance the ring state.
  // Zero size is tested before free space, so a drop never stalls.
  function automatic ring_result_t produce_descriptor(input copy_req_t r);
    ring_result_t        res;
    logic [BurstW-1:0]   cap;
    logic [63:0]         len;
    logic [RingBits-1:0] room;
    res.status   = StatusIdle;
    res.offset   = '0;
    res.flags    = '0;
    res.src      = '0;
    res.dst      = '0;
    res.count    = '0;
    res.db_valid = 1'b0;
    res.db_ptr   = '0;
    if (ring_on) begin
      if (r.cmd == CmdTick) begin
        // Idle tick flushes the doorbell only when descriptors are pending
        if (batch_fill != 8'd0) begin
          res.db_valid = 1'b1;
          res.db_ptr   = ring_head;
          batch_fill   = 8'd0;
        end
      end else if (r.size == 64'd0) begin
        res.status = StatusDropped;
      end else begin
        // Burst register of zero acts as one; above the limit acts as the limit
        cap = (burst_cap == '0) ? BurstW'(1) : burst_cap;
        if (cap > BurstLimit) cap = BurstLimit;
        len  = (r.size > 64'(cap)) ? 64'(cap) : r.size;
        room = r.rptr - ring_head - RingBits'(1);
        if (room < RingBits'(DescBytes)) begin
          res.status  = StatusStall;
          stall_count = stall_count + 64'd1;
        end else begin
          res.status  = StatusWritten;
          res.offset  = ring_head;
          res.flags   = r.flags;
          res.src     = r.src;
          res.dst     = r.dst;
          res.count   = 21'(len - 64'd1);
          ring_head   = ring_head + RingBits'(DescBytes);
          desc_total  = desc_total + 64'd1;
          bytes_total = bytes_total + len;
          batch_fill  = batch_fill + 8'd1;
          if (batch_fill >= batch_size) begin
            res.db_valid = 1'b1;
            res.db_ptr   = ring_head;
            batch_fill   = 8'd0;
          end
        end
      end
    end
    res.n_desc  = desc_total;
    res.n_bytes = bytes_total;
    res.n_stall = stall_count;
    return res;
  endfunction

  // Compare each accepted result item with the oldest prediction
  always @(posedge clk_i) begin
    ring_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (ring_results_q.size() == 0) begin
        report_mismatch("result item with no prediction waiting");
      end else begin
        want = ring_results_q.pop_front();
        compare_field("status", status_o, want.status);
        compare_field("desc_offset", desc_offset_o, want.offset);
        compare_field("desc_flags", desc_flags_o, want.flags);
        compare_field("desc_src", desc_src_o, want.src);
        compare_field("desc_dst", desc_dst_o, want.dst);
        compare_field("desc_count", desc_count_o, want.count);
        compare_field("doorbell_valid", doorbell_valid_o, want.db_valid);
        compare_field("doorbell_ptr", doorbell_ptr_o, want.db_ptr);
        compare_field("total_descriptors", total_descriptors_o, want.n_desc);
        compare_field("total_bytes", total_bytes_o, want.n_bytes);
        compare_field("total_stalls", total_stalls_o, want.n_stall);
      end
    end
  end

  function automatic copy_req_t make_req(input bit cmd, input logic [63:0] src,
                                         input logic [63:0] dst, input logic [63:0] size,
                                         input logic [1:0] flags,
                                         input logic [RingBits-1:0] rptr);
    copy_req_t r;
    r.cmd   = cmd;
    r.src   = src;
    r.dst   = dst;
    r.size  = size;
    r.flags = flags;
    r.rptr  = rptr;
    return r;
  endfunction

  // Send one item. Called at a rising edge; returns at the edge that accepts
  // it, with valid still high so a back-to-back item keeps the channel busy.
  task automatic send_item(input copy_req_t r, output dmarp_status_e got_status);
    ring_result_t res;
    if (!steady) begin
      while ($urandom_range(99) < 20) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    command_i    <= r.cmd;
    src_addr_i   <= r.src;
    dst_addr_i   <= r.dst;
    size_bytes_i <= r.size;
    req_flags_i  <= r.flags;
    read_ptr_i   <= r.rptr;
    do @(posedge clk_i); while (!in_ready_o);
    res = produce_descriptor(r);
    ring_results_q.push_back(res);
    got_status = res.status;
  endtask

  // Lower valid, let every predicted result arrive, then allow for the pipe
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (ring_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register while the block is idle and mirror it in the model
  task automatic write_reg(input dmarp_cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    wait_for_drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgRingEnable:    ring_on    = data[0];
      CfgMaxBurst:      burst_cap  = data[BurstW-1:0];
      CfgDoorbellBatch: batch_size = data[BatchW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_ring_regs(input logic en, input logic [BurstW-1:0] burst,
                                 input logic [BatchW-1:0] batch);
    write_reg(CfgRingEnable, CfgDataW'(en));
    write_reg(CfgMaxBurst, CfgDataW'(burst));
    write_reg(CfgDoorbellBatch, CfgDataW'(batch));
  endtask

  // Random traffic. Mostly well-formed copies; the read pointer is usually
  // the head (empty ring), often just past it to hit the full boundary, and
  // sometimes anywhere. A stalled copy is resent once space has been freed.
  task automatic run_random_phase(input int n_items, input int tick_pct);
    copy_req_t     r;
    copy_req_t     last;
    dmarp_status_e st;
    bit            retry;
    int            pick;
    logic [63:0]   eff_cap;
    retry = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      if (retry) begin
        r      = last;
        r.rptr = ring_head;
      end else begin
        r.cmd   = ($urandom_range(99) < tick_pct) ? CmdTick : CmdCopy;
        r.src   = {$urandom, $urandom};
        r.dst   = {$urandom, $urandom};
        r.flags = 2'($urandom_range(3));
        eff_cap = (burst_cap == '0) ? 64'd1 :
                  (burst_cap > BurstLimit) ? 64'(BurstLimit) : 64'(burst_cap);
        pick = $urandom_range(99);
        if (pick < 4)       r.size = 64'd0;
        else if (pick < 44) r.size = 64'($urandom_range(1, 4096));
        else if (pick < 64) r.size = eff_cap - 64'd1 + 64'($urandom_range(2));
        else if (pick < 84) r.size = {$urandom, $urandom};
        else                r.size = 64'($urandom_range(1, 4194304));
        pick = $urandom_range(99);
        if (pick < 50)      r.rptr = ring_head;
        else if (pick < 75) r.rptr = ring_head + RingBits'($urandom_range(1, 40));
        else                r.rptr = RingBits'($urandom);
      end
      send_item(r, st);
      last  = r;
      retry = (st == StatusStall) && !retry;
    end
  endtask

  // Ring disabled after reset: every kind of item answers idle, totals stay
  task automatic test_ring_disabled();
    dmarp_status_e st;
    send_item(make_req(CmdCopy, AllOnes, AllOnes, 64'd100, 2'd3, '0), st);
    send_item(make_req(CmdTick, '0, '0, '0, 2'd0, '0), st);
    send_item(make_req(CmdCopy, 64'h1, 64'h2, 64'd0, 2'd1, RingBits'(1)), st);
    send_item(make_req(CmdCopy, 64'h3, 64'h4, AllOnes, 2'd2, RingBits'(1)), st);
  endtask

  // Reset values of burst and batch with the ring switched on
  task automatic test_reset_defaults();
    write_reg(CfgRingEnable, CfgDataW'(1));
    run_random_phase(40, 0);
  endtask

  task automatic test_directed();
    dmarp_status_e st;
    write_ring_regs(1'b1, BurstLimit, BatchW'(3));
    // Idle tick: a doorbell only if descriptors are still pending
    send_item(make_req(CmdTick, AllOnes, AllOnes, AllOnes, 2'd3, AllOnes[RingBits-1:0]), st);
    // Zero size on a full ring: dropped, not stalled
    send_item(make_req(CmdCopy, 64'h10, 64'h20, 64'd0, 2'd0, ring_head + RingBits'(1)), st);
    send_item(make_req(CmdCopy, 64'd0, AllOnes, 64'd1, 2'd0, ring_head), st);
    // Largest size clamps to the burst limit
    send_item(make_req(CmdCopy, AllOnes, 64'd0, AllOnes, 2'd3, ring_head), st);
    // Third descriptor fills the batch and rings the doorbell
    send_item(make_req(CmdCopy, 64'hA5A5, 64'h5A5A, 64'd2097152, 2'd1, ring_head), st);
    send_item(make_req(CmdCopy, 64'h1234, 64'h5678, 64'd2097153, 2'd2, ring_head), st);
    // Full ring boundary: one and 32 bytes past the head stall, 33 does not
    send_item(make_req(CmdCopy, 64'h1, 64'h2, 64'd64, 2'd0, ring_head + RingBits'(1)), st);
    send_item(make_req(CmdCopy, 64'h1, 64'h2, 64'd64, 2'd0, ring_head + RingBits'(32)), st);
    send_item(make_req(CmdCopy, 64'h1, 64'h2, 64'd64, 2'd0, ring_head + RingBits'(33)), st);
    send_item(make_req(CmdCopy, 64'h7, 64'h8, 64'd9, 2'd1, AllOnes[RingBits-1:0]), st);
    // Ticks right after the batch doorbell: nothing pending, so no doorbell
    send_item(make_req(CmdTick, '0, '0, 64'd5, 2'd0, ring_head), st);
    send_item(make_req(CmdTick, '0, '0, 64'd5, 2'd0, ring_head), st);
    // Burst register zero acts as one; batch zero rings after every descriptor
    write_ring_regs(1'b1, '0, '0);
    send_item(make_req(CmdCopy, 64'h11, 64'h22, 64'd5, 2'd3, ring_head), st);
    send_item(make_req(CmdCopy, 64'h33, 64'h44, 64'd1, 2'd2, ring_head), st);
    // Burst register above the limit acts as the limit
    write_ring_regs(1'b1, BurstW'(22'h3FFFFF), BatchW'(16));
    send_item(make_req(CmdCopy, 64'h55, 64'h66, 64'h3FFFFF, 2'd1, ring_head), st);
    // Disabled ring keeps the pending count: no doorbell on a tick
    write_reg(CfgRingEnable, CfgDataW'(0));
    send_item(make_req(CmdTick, '0, '0, '0, 2'd0, ring_head), st);
    send_item(make_req(CmdCopy, 64'h77, 64'h88, 64'd8, 2'd0, ring_head), st);
    write_reg(CfgRingEnable, CfgDataW'(1));
    send_item(make_req(CmdTick, '0, '0, '0, 2'd0, ring_head), st);
  endtask

  // Several settings, extremes among them
  task automatic test_random_settings();
    write_ring_regs(1'b1, BurstW'(1), BatchW'(1));
    run_random_phase(50, 10);
    write_ring_regs(1'b1, BurstW'(22'h3FFFFF), BatchW'(0));
    run_random_phase(50, 10);
    write_ring_regs(1'b1, BurstW'($urandom_range(2, 4096)), BatchW'($urandom_range(2, 32)));
    run_random_phase(50, 15);
    write_ring_regs(1'b0, BurstW'($urandom), BatchW'($urandom));
    run_random_phase(20, 20);
    write_ring_regs(1'b1, BurstLimit, BatchW'($urandom_range(2, 254)));
    run_random_phase(50, 5);
  endtask

  // Largest batch: no ticks, so the pending count climbs all the way up.
  // First half runs with neither side idling.
  task automatic test_full_batch();
    write_ring_regs(1'b1, BurstLimit, BatchW'(255));
    steady = 1'b1;
    run_random_phase(190, 0);
    steady = 1'b0;
    run_random_phase(190, 0);
    run_random_phase(5, 100);
  endtask

  initial begin
    ring_head   = '0;
    batch_fill  = '0;
    desc_total  = '0;
    bytes_total = '0;
    stall_count = '0;
    ring_on     = 1'b0;
    burst_cap   = BurstLimit;
    batch_size  = BatchReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ring_disabled();
    test_reset_defaults();
    test_directed();
    test_random_settings();
    test_full_batch();

    // Drain and give the pipe time to show any stray result
    wait_for_drain();
    repeat (20) @(posedge clk_i);
    if (ring_results_q.size() != 0) report_mismatch("predictions left over at the end");
    if (error_count == 0) begin
      $display("dma_descriptor_ring_producer_tb passed");
    end else begin
      $display("dma_descriptor_ring_producer_tb failed");
    end
    $finish;
  end

endmodule
